FILE: design/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg: shared types and constants for the descriptive statistics unit
// Beat formats, status codes and fixed-point widths used by the top level, log2 and square-root units.
// ----------------------------------------------------------------------------
package dsu_pkg;

   localparam int DEFAULT_MAX_SAMPLES = 64;
   localparam int SAMPLE_W            = 32;
   // reciprocal of a raw sample is 2^RECIP_SHIFT / r
   localparam int RECIP_SHIFT         = 48;
   // log2 in Q5.32
   localparam int LOG_INT_W           = 5;
   localparam int LOG_FRAC_W          = 32;
   localparam int LOG_W               = LOG_INT_W + LOG_FRAC_W;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO     = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                is_last;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] arith_mean;
      logic [SAMPLE_W-1:0] std_dev;
      logic [SAMPLE_W-1:0] geo_mean;
      logic [SAMPLE_W-1:0] harm_mean;
      logic [SAMPLE_W-1:0] max_value;
      logic [SAMPLE_W-1:0] min_value;
      logic [1:0]          status;
   } rsp_type;

endpackage

FILE: design/dsu_div.sv
// ----------------------------------------------------------------------------
// dsu_div: iterative restoring divider
// One quotient bit per cycle. The caller left-aligns the dividend and gives
// the number of bits to process; the quotient lands in the low bits.
// ----------------------------------------------------------------------------
module dsu_div #(
   parameter int NUM_W = 71,
   parameter int DEN_W = 56
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [$clog2(NUM_W+1)-1:0] iters,
   input  logic [NUM_W-1:0]           num,
   input  logic [DEN_W-1:0]           den,
   output logic                       done,
   output logic [NUM_W-1:0]           quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] diff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      shifted = {rem_ff, q_ff[NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den};
      if (start) begin
         run_in = 1'b1;
         cnt_in = iters;
         rem_in = '0;
         q_in   = num;
      end else if (run_ff) begin
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

FILE: design/dsu_log2.sv
// ----------------------------------------------------------------------------
// dsu_log2: iterative base-2 logarithm, Q5.32
// Leading-one detect for the integer part, then one truncated squaring of
// the Q1.31 mantissa per cycle for each of the 32 fraction bits.
// ----------------------------------------------------------------------------
module dsu_log2 (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dsu_pkg::SAMPLE_W-1:0]   arg,
   output logic                           done,
   output logic [dsu_pkg::LOG_W-1:0]      result
);
   import dsu_pkg::*;

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [LOG_INT_W-1:0]  exp_ff, exp_in;
   logic [LOG_FRAC_W-1:0] frac_ff, frac_in;
   logic [31:0]           mant_ff, mant_in;
   logic [LOG_INT_W-1:0]  lead;
   logic [63:0]           prod;
   logic [32:0]           sq;

   always_comb begin
      lead = '0;
      for (int i = 0; i < SAMPLE_W; i++) begin
         if (arg[i]) begin
            lead = LOG_INT_W'(i);
         end
      end
      prod    = 64'(mant_ff) * 64'(mant_ff);
      sq      = prod[63:31];
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      exp_in  = exp_ff;
      frac_in = frac_ff;
      mant_in = mant_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = 6'd32;
         exp_in  = lead;
         frac_in = '0;
         mant_in = arg << (5'd31 - lead);
      end else if (run_ff) begin
         if (sq[32]) begin
            frac_in = {frac_ff[LOG_FRAC_W-2:0], 1'b1};
            mant_in = sq[32:1];
         end else begin
            frac_in = {frac_ff[LOG_FRAC_W-2:0], 1'b0};
            mant_in = sq[31:0];
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      exp_ff  <= exp_in;
      frac_ff <= frac_in;
      mant_ff <= mant_in;
   end

   assign done   = done_ff;
   assign result = {exp_ff, frac_ff};

endmodule

FILE: design/dsu_sqrt.sv
// ----------------------------------------------------------------------------
// dsu_sqrt: iterative integer square root of a 64-bit value
// Digit-by-digit method, one result bit per cycle.
// ----------------------------------------------------------------------------
module dsu_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [63:0]                  arg,
   output logic                         done,
   output logic [dsu_pkg::SAMPLE_W-1:0] root
);
   import dsu_pkg::*;

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      val_in  = val_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (start) begin
         run_in = 1'b1;
         val_in = arg;
         res_in = '0;
         bit_in = 64'd1 << 62;
      end else if (run_ff) begin
         if (val_ff >= trial) begin
            val_in = val_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      val_ff <= val_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[SAMPLE_W-1:0];

endmodule

FILE: design/descriptive_statistics_unit.sv
// Non-last sample: busy while its serial reciprocal divide and its log2 run.
// Zero or dropped non-last sample: accepted with no busy time at all.
// Last sample: busy until the result beat, for a valid set mostly in the
//   32 log2 evaluations of the geometric-mean bit search.
// One result beat per set, strobed for one cycle; the receiver cannot stall.
// Reset is synchronous; it clears control and accumulators, not the sample memory.
// ----------------------------------------------------------------------------
// descriptive_statistics_unit: mean, std dev, geometric/harmonic mean, max, min
// Samples are stored and accumulated as they arrive; the last one starts a
// sequencer that drives a shared divider, log2 unit and square-root unit.
// ----------------------------------------------------------------------------
module descriptive_statistics_unit #(
   parameter int MAX_SAMPLES = dsu_pkg::DEFAULT_MAX_SAMPLES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dsu_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dsu_pkg::rsp_type rsp_data
);
   import dsu_pkg::*;

   localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W     = $clog2(MAX_SAMPLES);
   localparam int SUM_W     = SAMPLE_W + CNT_W;
   localparam int RSUM_W    = RECIP_SHIFT + 1 + CNT_W;
   localparam int LSUM_W    = LOG_W + CNT_W;
   localparam int SQ_W      = 2 * SAMPLE_W + CNT_W;
   localparam int DIV_NUM_W = SQ_W;
   localparam int DIV_DEN_W = RSUM_W;
   localparam int DIV_IW    = $clog2(DIV_NUM_W + 1);

   // sequencer states
   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_SAMPLE = 13'b0000000000010,  // reciprocal and log2 of new sample
      S_FIN    = 13'b0000000000100,  // end of set: error check, start mean
      S_MEAN   = 13'b0000000001000,
      S_VRD    = 13'b0000000010000,  // second pass: memory read
      S_VSUB   = 13'b0000000100000,  // |x - mean|
      S_VMUL   = 13'b0000001000000,  // square
      S_VACC   = 13'b0000010000000,  // accumulate
      S_VAR    = 13'b0000100000000,
      S_SQRT   = 13'b0001000000000,
      S_MLOG   = 13'b0010000000000,
      S_GEO    = 13'b0100000000000,  // bit search on exp2 of mean log
      S_HARM   = 13'b1000000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic                  last_ff, last_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [1:0]            err_ff, err_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [RSUM_W-1:0]     rsum_ff, rsum_in;
   logic [LSUM_W-1:0]     lsum_ff, lsum_in;
   logic [SAMPLE_W-1:0]   max_ff, max_in;
   logic [SAMPLE_W-1:0]   min_ff, min_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [SAMPLE_W-1:0]   mean_ff, mean_in;
   logic [SAMPLE_W-1:0]   dev_ff, dev_in;
   logic [63:0]           sq_ff, sq_in;
   logic [SQ_W-1:0]       acc_ff, acc_in;
   logic [LSUM_W-1:0]     mlog_ff, mlog_in;
   logic [SAMPLE_W-1:0]   std_ff, std_in;
   logic [SAMPLE_W-1:0]   geo_ff, geo_in;
   logic [4:0]            gbit_ff, gbit_in;
   logic                  rdone_ff, rdone_in;
   logic                  ldone_ff, ldone_in;

   logic                  div_start_ff, div_start_in;
   logic [DIV_IW-1:0]     div_iter_ff, div_iter_in;
   logic [DIV_NUM_W-1:0]  div_num_ff, div_num_in;
   logic [DIV_DEN_W-1:0]  div_den_ff, div_den_in;
   logic                  log_start_ff, log_start_in;
   logic [SAMPLE_W-1:0]   log_arg_ff, log_arg_in;
   logic                  sqrt_start_ff, sqrt_start_in;
   logic [63:0]           sqrt_arg_ff, sqrt_arg_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  wr_en;
   logic [SAMPLE_W-1:0]   rd_data_ff;
   logic [SAMPLE_W-1:0]   store [MAX_SAMPLES];

   logic                  div_done;
   logic [DIV_NUM_W-1:0]  div_quot;
   logic                  log_done;
   logic [LOG_W-1:0]      log_result;
   logic                  sqrt_done;
   logic [SAMPLE_W-1:0]   sqrt_root;

   logic                  clear;
   logic                  rdone_now, ldone_now;
   logic [SAMPLE_W-1:0]   geo_pick;

   dsu_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .iters (div_iter_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   dsu_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start_ff),
      .arg    (log_arg_ff),
      .done   (log_done),
      .result (log_result)
   );

   dsu_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start_ff),
      .arg   (sqrt_arg_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      sum_in        = sum_ff;
      rsum_in       = rsum_ff;
      lsum_in       = lsum_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      idx_in        = idx_ff;
      mean_in       = mean_ff;
      dev_in        = dev_ff;
      sq_in         = sq_ff;
      acc_in        = acc_ff;
      mlog_in       = mlog_ff;
      std_in        = std_ff;
      geo_in        = geo_ff;
      gbit_in       = gbit_ff;
      rdone_in      = rdone_ff;
      ldone_in      = ldone_ff;
      div_start_in  = 1'b0;
      div_iter_in   = div_iter_ff;
      div_num_in    = div_num_ff;
      div_den_in    = div_den_ff;
      log_start_in  = 1'b0;
      log_arg_in    = log_arg_ff;
      sqrt_start_in = 1'b0;
      sqrt_arg_in   = sqrt_arg_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      clear         = 1'b0;
      rdone_now     = rdone_ff | div_done;
      ldone_now     = ldone_ff | log_done;
      geo_pick      = ({{CNT_W{1'b0}}, log_result} <= mlog_ff) ? log_arg_ff : geo_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               last_in = req_data.is_last;
               if (req_data.sample == '0) begin
                  if (err_ff == STATUS_OK) begin
                     err_in = STATUS_ZERO;
                  end
                  if (req_data.is_last) begin
                     state_in = S_FIN;
                  end
               end else if (count_ff >= CNT_W'(MAX_SAMPLES)) begin
                  if (err_ff == STATUS_OK) begin
                     err_in = STATUS_OVERFLOW;
                  end
                  if (req_data.is_last) begin
                     state_in = S_FIN;
                  end
               end else begin
                  wr_en        = 1'b1;
                  sample_in    = req_data.sample;
                  count_in     = count_ff + CNT_W'(1);
                  if (req_data.sample > max_ff) begin
                     max_in = req_data.sample;
                  end
                  if (req_data.sample < min_ff) begin
                     min_in = req_data.sample;
                  end
                  // 2^48 / x: dividend left-aligned, 49 bits processed
                  div_start_in = 1'b1;
                  div_iter_in  = DIV_IW'(RECIP_SHIFT + 1);
                  div_num_in   = DIV_NUM_W'(1) << (DIV_NUM_W - 1);
                  div_den_in   = DIV_DEN_W'(req_data.sample);
                  log_start_in = 1'b1;
                  log_arg_in   = req_data.sample;
                  rdone_in     = 1'b0;
                  ldone_in     = 1'b0;
                  state_in     = S_SAMPLE;
               end
            end
         end
         S_SAMPLE: begin
            rdone_in = rdone_now;
            ldone_in = ldone_now;
            if (rdone_now && ldone_now) begin
               sum_in   = sum_ff + SUM_W'(sample_ff);
               rsum_in  = rsum_ff + RSUM_W'(div_quot[RECIP_SHIFT:0]);
               lsum_in  = lsum_ff + LSUM_W'(log_result);
               state_in = last_ff ? S_FIN : S_IDLE;
            end
         end
         S_FIN: begin
            if (err_ff != STATUS_OK || count_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '0;
               rsp_data_in.status = err_ff;
               clear    = 1'b1;
               state_in = S_IDLE;
            end else begin
               div_start_in = 1'b1;
               div_iter_in  = DIV_IW'(DIV_NUM_W);
               div_num_in   = DIV_NUM_W'(sum_ff);
               div_den_in   = DIV_DEN_W'(count_ff);
               state_in     = S_MEAN;
            end
         end
         S_MEAN: begin
            if (div_done) begin
               mean_in  = div_quot[SAMPLE_W-1:0];
               idx_in   = '0;
               acc_in   = '0;
               state_in = S_VRD;
            end
         end
         S_VRD: begin
            state_in = S_VSUB;
         end
         S_VSUB: begin
            dev_in   = (rd_data_ff >= mean_ff) ? rd_data_ff - mean_ff : mean_ff - rd_data_ff;
            state_in = S_VMUL;
         end
         S_VMUL: begin
            sq_in    = 64'(dev_ff) * 64'(dev_ff);
            state_in = S_VACC;
         end
         S_VACC: begin
            acc_in = acc_ff + SQ_W'(sq_ff);
            if (idx_ff == count_ff - CNT_W'(1)) begin
               div_start_in = 1'b1;
               div_iter_in  = DIV_IW'(DIV_NUM_W);
               div_num_in   = DIV_NUM_W'(acc_in);
               div_den_in   = DIV_DEN_W'(count_ff);
               state_in     = S_VAR;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_VRD;
            end
         end
         S_VAR: begin
            if (div_done) begin
               sqrt_start_in = 1'b1;
               sqrt_arg_in   = div_quot[63:0];
               state_in      = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               std_in       = sqrt_root;
               div_start_in = 1'b1;
               div_iter_in  = DIV_IW'(DIV_NUM_W);
               div_num_in   = DIV_NUM_W'(lsum_ff);
               div_den_in   = DIV_DEN_W'(count_ff);
               state_in     = S_MLOG;
            end
         end
         S_MLOG: begin
            if (div_done) begin
               mlog_in      = div_quot[LSUM_W-1:0];
               geo_in       = '0;
               gbit_in      = 5'd31;
               log_start_in = 1'b1;
               log_arg_in   = SAMPLE_W'(1) << 31;
               state_in     = S_GEO;
            end
         end
         S_GEO: begin
            // keep the candidate bit if log2 stays at or below the mean log
            if (log_done) begin
               geo_in = geo_pick;
               if (gbit_ff == 5'd0) begin
                  div_start_in = 1'b1;
                  div_iter_in  = DIV_IW'(DIV_NUM_W);
                  div_num_in   = DIV_NUM_W'(count_ff) << RECIP_SHIFT;
                  div_den_in   = rsum_ff;
                  state_in     = S_HARM;
               end else begin
                  gbit_in      = gbit_ff - 5'd1;
                  log_start_in = 1'b1;
                  log_arg_in   = geo_pick | (SAMPLE_W'(1) << (gbit_ff - 5'd1));
               end
            end
         end
         S_HARM: begin
            if (div_done) begin
               rsp_strobe_in          = 1'b1;
               rsp_data_in.arith_mean = mean_ff;
               rsp_data_in.std_dev    = std_ff;
               rsp_data_in.geo_mean   = geo_ff;
               rsp_data_in.harm_mean  = (|div_quot[DIV_NUM_W-1:SAMPLE_W]) ?
                                        '1 : div_quot[SAMPLE_W-1:0];
               rsp_data_in.max_value  = max_ff;
               rsp_data_in.min_value  = min_ff;
               rsp_data_in.status     = STATUS_OK;
               clear    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // set done: back to the empty state
      if (clear) begin
         count_in = '0;
         err_in   = STATUS_OK;
         sum_in   = '0;
         rsum_in  = '0;
         lsum_in  = '0;
         max_in   = '0;
         min_in   = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         err_ff        <= STATUS_OK;
         sum_ff        <= '0;
         rsum_ff       <= '0;
         lsum_ff       <= '0;
         max_ff        <= '0;
         min_ff        <= '1;
         rdone_ff      <= 1'b0;
         ldone_ff      <= 1'b0;
         div_start_ff  <= 1'b0;
         log_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         err_ff        <= err_in;
         sum_ff        <= sum_in;
         rsum_ff       <= rsum_in;
         lsum_ff       <= lsum_in;
         max_ff        <= max_in;
         min_ff        <= min_in;
         rdone_ff      <= rdone_in;
         ldone_ff      <= ldone_in;
         div_start_ff  <= div_start_in;
         log_start_ff  <= log_start_in;
         sqrt_start_ff <= sqrt_start_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      mean_ff     <= mean_in;
      dev_ff      <= dev_in;
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      mlog_ff     <= mlog_in;
      std_ff      <= std_in;
      geo_ff      <= geo_in;
      gbit_ff     <= gbit_in;
      div_iter_ff <= div_iter_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      log_arg_ff  <= log_arg_in;
      sqrt_arg_ff <= sqrt_arg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sample memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[count_ff[IDX_W-1:0]] <= req_data.sample;
      end
      rd_data_ff <= store[idx_ff[IDX_W-1:0]];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an input beat");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != STATUS_OK) |->
      (rsp_data.arith_mean == '0 && rsp_data.std_dev == '0 &&
       rsp_data.geo_mean == '0 && rsp_data.harm_mean == '0 &&
       rsp_data.max_value == '0 && rsp_data.min_value == '0))
      else $error("error result carries nonzero fields");

   a_max_ge_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_OK) |->
      (rsp_data.max_value >= rsp_data.min_value))
      else $error("max below min in result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond capacity");

   a_cleared_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (count_ff == '0 && err_ff == STATUS_OK))
      else $error("state not cleared with result beat");
`endif

endmodule
